@@ rtl/core/cfd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// CR/LF command frame decoder package
// Shared constants and types for the command line receiver and its result
// arithmetic.
// ----------------------------------------------------------------------------
package cfd_pkg;

   localparam int LINE_LIMIT_DEFAULT = 30;
   localparam int STORE_DEPTH        = 4;
   localparam int INDEX_WIDTH        = $clog2(STORE_DEPTH);

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;

   localparam int ANGLE_OFFSET = 100;
   localparam int MOTOR_CAP    = 14;

   localparam int ANGLE_WIDTH = 16;
   localparam int MOTOR_WIDTH = 9;

   typedef logic [7:0] char_type;
   typedef char_type [STORE_DEPTH-1:0] digits_type;
   typedef logic signed [ANGLE_WIDTH-1:0] angle_type;
   typedef logic signed [MOTOR_WIDTH-1:0] motor_type;

endpackage
`default_nettype wire

@@ rtl/core/crlf_command_frame_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// CR/LF command frame decoder
// Receives serial bytes, collects a CR/LF terminated command line and emits
// the decoded steering angle and motor level for every completed line.
// ----------------------------------------------------------------------------
// The block accepts one byte per clock cycle while req_ready is high. A byte
// that completes a line (an LF directly after a CR) has its result moved
// through the snapshot register that holds the stored digits and then the
// result register, which offers it for transfer. The result register
// parts the two channels, so bytes keep being taken while a result waits,
// until a second completed line has moved into the snapshot register; from
// then on no byte is taken until the waiting result is transferred. Lines
// longer than LINE_LIMIT data bytes, and any byte other than LF after a CR,
// restart reception silently.
// ----------------------------------------------------------------------------
module crlf_command_frame_decoder import cfd_pkg::*; #(
   parameter int LINE_LIMIT = LINE_LIMIT_DEFAULT
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_ready,
   input  wire char_type  req_rx_byte,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output angle_type      rsp_steer_angle,
   output motor_type      rsp_motor_level
);

   localparam int CountWidth = $clog2(LINE_LIMIT + 1);

   logic                  cr_seen_ff,     cr_seen_in;
   logic [CountWidth-1:0] count_ff,       count_in;
   digits_type            store_ff,       store_in;
   logic                  stage_valid_ff, stage_valid_in;
   digits_type            stage_digits_ff;
   logic                  rsp_valid_ff,   rsp_valid_in;
   angle_type             angle_ff;
   motor_type             motor_ff;
   angle_type             angle_calc;
   motor_type             motor_calc;
   logic                  req_fire;
   logic                  stage_load;
   logic                  stage_move;
   logic                  rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign stage_move = stage_valid_ff && rsp_free;
   assign req_ready  = !stage_valid_ff || rsp_free;
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      cr_seen_in = cr_seen_ff;
      count_in   = count_ff;
      store_in   = store_ff;
      stage_load = 1'b0;
      if (req_fire) begin
         if (cr_seen_ff) begin
            cr_seen_in = 1'b0;
            count_in   = '0;
            stage_load = (req_rx_byte == CHAR_LF);
         end else if (req_rx_byte == CHAR_CR) begin
            cr_seen_in = 1'b1;
         end else begin
            if (count_ff < CountWidth'(STORE_DEPTH)) begin
               store_in[count_ff[INDEX_WIDTH-1:0]] = req_rx_byte;
            end
            if (count_ff == CountWidth'(LINE_LIMIT)) begin
               count_in = '0;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (stage_load) begin
         stage_valid_in = 1'b1;
      end else if (stage_move) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
      if (stage_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_seen_ff     <= 1'b0;
         count_ff       <= '0;
         store_ff       <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cr_seen_ff     <= cr_seen_in;
         count_ff       <= count_in;
         store_ff       <= store_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load) begin
         stage_digits_ff <= store_ff;
      end
      if (stage_move) begin
         angle_ff <= angle_calc;
         motor_ff <= motor_calc;
      end
   end

   cfd_result_calc u_result_calc (
      .digits      (stage_digits_ff),
      .steer_angle (angle_calc),
      .motor_level (motor_calc)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_steer_angle = angle_ff;
   assign rsp_motor_level = motor_ff;

endmodule
`default_nettype wire

@@ rtl/core/cfd_result_calc.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// CR/LF command frame decoder result arithmetic
// Turns the four stored ASCII bytes into the steering angle and the capped
// motor level.
// ----------------------------------------------------------------------------
module cfd_result_calc import cfd_pkg::*; (
   input  digits_type digits,
   output angle_type  steer_angle,
   output motor_type  motor_level
);

   logic signed [8:0]  digit_val [STORE_DEPTH];
   logic signed [16:0] value;
   logic signed [19:0] scaled;
   logic signed [19:0] quotient;
   logic signed [10:0] motor_raw;

   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         digit_val[i] = $signed({1'b0, digits[i]}) - $signed({1'b0, DIGIT_ZERO});
      end
   end

   // The angle divides by four with truncation towards zero.
   always_comb begin
      value = 17'(digit_val[0]) * 17'sd100 + 17'(digit_val[1]) * 17'sd10
            + 17'(digit_val[2]);
      scaled = (20'(ANGLE_OFFSET) - 20'(value)) * 20'sd3;
      if (scaled < 0) begin
         quotient = (scaled + 20'sd3) >>> 2;
      end else begin
         quotient = scaled >>> 2;
      end
      steer_angle = quotient[ANGLE_WIDTH-1:0];
   end

   always_comb begin
      motor_raw = 11'(digit_val[3]) * 11'sd4;
      if (motor_raw > 11'(MOTOR_CAP)) begin
         motor_level = MOTOR_WIDTH'(MOTOR_CAP);
      end else begin
         motor_level = motor_raw[MOTOR_WIDTH-1:0];
      end
   end

endmodule
`default_nettype wire
